// ===== design/vfve_pkg.sv =====
// Shared types, tables and arithmetic helpers for the voxel face vertex emitter.
package vfve_pkg;

    localparam int ATLAS_TILES_PER_ROW = 16;
    localparam int POSITION_WIDTH      = 32;
    localparam int TILE_CELL           = 65536 / ATLAS_TILES_PER_ROW;
    localparam int UV_INSET            = 32;

    // Q1.16 brightness constants
    localparam logic [15:0] AO_SPAN   = 16'd45875;   // 0.7
    localparam logic [19:0] AO_OFFSET = 20'd26214;   // 0.7 - 0.3
    localparam logic [16:0] BRIGHT_MAX = 17'd65536;

    typedef enum logic [2:0] {
        FACE_NEG_X = 3'd0,
        FACE_POS_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_NEG_Z = 3'd4,
        FACE_POS_Z = 3'd5
    } face_t;

    localparam logic [2:0] VERT_LAST = 3'd5;

    // Triangle corner order, indexed [face odd][vertex]
    localparam logic [1:0] ORDER_A [2][6] = '{
        '{2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3}
    };
    localparam logic [1:0] ORDER_B [2][6] = '{
        '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd2, 2'd3, 2'd1}
    };

    // Corner sign per axis, bit set means minus: {x, y, z}
    localparam logic [2:0] CORNER_NEG [6][4] = '{
        '{3'b111, 3'b110, 3'b101, 3'b100},
        '{3'b011, 3'b010, 3'b001, 3'b000},
        '{3'b101, 3'b100, 3'b001, 3'b000},
        '{3'b111, 3'b110, 3'b011, 3'b010},
        '{3'b111, 3'b101, 3'b011, 3'b001},
        '{3'b110, 3'b100, 3'b010, 3'b000}
    };

    // Far-edge flags of the atlas cell: {u, v}
    localparam logic [1:0] CORNER_UV [6][4] = '{
        '{2'b00, 2'b10, 2'b01, 2'b11},
        '{2'b10, 2'b00, 2'b11, 2'b01},
        '{2'b01, 2'b00, 2'b11, 2'b10},
        '{2'b00, 2'b01, 2'b10, 2'b11},
        '{2'b00, 2'b01, 2'b10, 2'b11},
        '{2'b10, 2'b11, 2'b00, 2'b01}
    };

    localparam logic [16:0] FACE_BRIGHT [6] = '{
        17'd39322, 17'd39322, 17'd65536, 17'd32768, 17'd52429, 17'd52429
    };

    typedef struct packed {
        logic [2:0]         face;
        logic [7:0]         tile;
        logic [35:0]        ao;
        logic [35:0]        lt;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [8:0]         half;
        logic               flip;
    } held_t;

    typedef struct packed {
        logic [2:0]         face;
        logic               last;
        logic [2:0]         neg;
        logic [1:0]         uvf;
        logic [8:0]         ao;
        logic [8:0]         lt;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [8:0]         half;
        logic [7:0]         tile;
    } s1_t;

    typedef struct packed {
        logic [2:0]         face;
        logic               last;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [8:0]         lt;
        logic signed [19:0] aof;
    } s2_t;

    typedef struct packed {
        logic        last;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] u;
        logic [15:0] v;
        logic [8:0]  lt;
        logic [17:0] br;
    } s3_t;

    typedef struct packed {
        logic        last;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  grey;
        logic [15:0] u;
        logic [15:0] v;
    } vert_t;

    // centre +/- half, saturated to the position range, reported in 32 bits
    function automatic logic [31:0] corner_coord(logic signed [31:0] c, logic [8:0] h,
                                                 logic neg);
        logic signed [63:0] sum;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi  = (64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1;
        lo  = -hi - 64'sd1;
        sum = neg ? 64'(c) - $signed({55'd0, h}) : 64'(c) + $signed({55'd0, h});
        if (sum > hi)
            sum = hi;
        if (sum < lo)
            sum = lo;
        return sum[31:0];
    endfunction

    function automatic logic [15:0] tex_coord(logic [7:0] index, logic flag);
        logic [23:0] c;
        c = 24'(index) * 24'(TILE_CELL)
            + (flag ? 24'(TILE_CELL - UV_INSET) : 24'(UV_INSET));
        return (c > 24'h00FFFF) ? 16'hFFFF : c[15:0];
    endfunction

endpackage

// ===== design/vfve_face_if.sv =====
// Face item channel: valid/ready handshake and face payload.
interface vfve_face_if;
    logic               valid;
    logic               ready;
    logic [2:0]         face;
    logic               face_visible;
    logic [7:0]         tile;
    logic [35:0]        ao_corners;
    logic [35:0]        light_corners;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [8:0]         half_size;

    modport source (
        output valid, face, face_visible, tile, ao_corners, light_corners,
               centre_x, centre_y, centre_z, half_size,
        input  ready
    );
    modport sink (
        input  valid, face, face_visible, tile, ao_corners, light_corners,
               centre_x, centre_y, centre_z, half_size,
        output ready
    );
endinterface

// ===== design/vfve_vert_if.sv =====
// Vertex channel: valid/ready handshake and vertex payload.
interface vfve_vert_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [7:0]         grey_level;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;

    modport source (
        output valid, vert_x, vert_y, vert_z, grey_level, tex_u, tex_v, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vert_x, vert_y, vert_z, grey_level, tex_u, tex_v, last_vertex,
        output ready
    );
endinterface

// ===== design/voxel_face_vertex_emitter.sv =====
// Voxel face vertex emitter: face sequencer and four-stage vertex pipeline.
//
// One face item in, six vertices out (two triangles), one vertex per cycle while the
// output is ready; a hidden face, or a face index of six or seven, is taken and gives
// nothing. The next face is taken in the cycle that issues the sixth vertex of the
// current one, so faces stream without gaps. A face is held in a register, and each
// vertex then passes corner select, position, texture and occlusion product,
// face-brightness product, then clamp and grey byte into the output register. Every
// stage holds its own valid bit and moves when the stage after it is free, so output
// back-pressure stalls the pipe without loss.
module voxel_face_vertex_emitter
    import vfve_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    vfve_face_if.sink      face_item,
    vfve_vert_if.source    vertex
);

    held_t      held_reg;
    logic       busy_reg;
    logic [2:0] step_reg;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    vert_t s4_reg, s4_next;
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    logic s1_en, s2_en, s3_en, s4_en;
    logic take, take_live;
    logic [9:0] diag_a, diag_b;

    // stage enables, back to front
    assign s4_en = !s4_valid_reg || vertex.ready;
    assign s3_en = !s3_valid_reg || s4_en;
    assign s2_en = !s2_valid_reg || s3_en;
    assign s1_en = !s1_valid_reg || s2_en;

    assign face_item.ready = !busy_reg || (step_reg == VERT_LAST && s1_en);
    assign take            = face_item.valid && face_item.ready;
    assign take_live       = take && face_item.face_visible
                             && (face_item.face <= FACE_POS_Z);

    assign diag_a = 10'(face_item.ao_corners[8:0]) + 10'(face_item.ao_corners[35:27]);
    assign diag_b = 10'(face_item.ao_corners[17:9]) + 10'(face_item.ao_corners[26:18]);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (take_live)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg && s1_en)
        begin
            if (step_reg == VERT_LAST)
            begin
                busy_reg <= 1'b0;
                step_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_reg.face <= face_item.face;
            held_reg.tile <= face_item.tile;
            held_reg.ao   <= face_item.ao_corners;
            held_reg.lt   <= face_item.light_corners;
            held_reg.cx   <= face_item.centre_x;
            held_reg.cy   <= face_item.centre_y;
            held_reg.cz   <= face_item.centre_z;
            held_reg.half <= face_item.half_size;
            held_reg.flip <= (diag_a > diag_b);
        end
    end

    // stage 1: corner of this vertex
    always_comb
    begin
        logic [1:0] j;
        j = held_reg.flip ? ORDER_B[held_reg.face[0]][step_reg]
                          : ORDER_A[held_reg.face[0]][step_reg];
        s1_next.face = held_reg.face;
        s1_next.last = (step_reg == VERT_LAST);
        s1_next.neg  = CORNER_NEG[held_reg.face][j];
        s1_next.uvf  = CORNER_UV[held_reg.face][j];
        s1_next.ao   = held_reg.ao[9 * j +: 9];
        s1_next.lt   = held_reg.lt[9 * j +: 9];
        s1_next.cx   = held_reg.cx;
        s1_next.cy   = held_reg.cy;
        s1_next.cz   = held_reg.cz;
        s1_next.half = held_reg.half;
        s1_next.tile = held_reg.tile;
    end

    // stage 2: positions, texture coordinates, occlusion factor
    always_comb
    begin
        logic [17:0] rem;
        logic [33:0] prod;
        logic [7:0]  col;
        logic [7:0]  row;
        rem  = 18'd131072 - {1'b0, s1_reg.ao, 8'd0};
        prod = 34'(AO_SPAN) * 34'(rem);
        col  = 8'(s1_reg.tile % ATLAS_TILES_PER_ROW);
        row  = 8'(s1_reg.tile / ATLAS_TILES_PER_ROW);
        s2_next.face = s1_reg.face;
        s2_next.last = s1_reg.last;
        s2_next.x    = corner_coord(s1_reg.cx, s1_reg.half, s1_reg.neg[2]);
        s2_next.y    = corner_coord(s1_reg.cy, s1_reg.half, s1_reg.neg[1]);
        s2_next.z    = corner_coord(s1_reg.cz, s1_reg.half, s1_reg.neg[0]);
        s2_next.u    = tex_coord(col, s1_reg.uvf[1]);
        s2_next.v    = tex_coord(row, s1_reg.uvf[0]);
        s2_next.lt   = s1_reg.lt;
        s2_next.aof  = $signed({2'b00, prod[33:16]}) - $signed(AO_OFFSET);
    end

    // stage 3: face brightness times occlusion factor
    always_comb
    begin
        logic [33:0] prod;
        prod = 34'(FACE_BRIGHT[s2_reg.face]) * 34'(s2_reg.aof[16:0]);
        s3_next.last = s2_reg.last;
        s3_next.x    = s2_reg.x;
        s3_next.y    = s2_reg.y;
        s3_next.z    = s2_reg.z;
        s3_next.u    = s2_reg.u;
        s3_next.v    = s2_reg.v;
        s3_next.lt   = s2_reg.lt;
        // non-positive factor leaves the light value alone
        s3_next.br   = (s2_reg.aof > 20'sd0) ? prod[33:16] : 18'd0;
    end

    // stage 4: max with light, clamp, scale to a byte
    always_comb
    begin
        logic [17:0] b;
        logic [24:0] g;
        b = {1'b0, s3_reg.lt, 8'd0};
        if (s3_reg.br > b)
            b = s3_reg.br;
        if (b > 18'(BRIGHT_MAX))
            b = 18'(BRIGHT_MAX);
        g = {b[16:0], 8'd0} - 25'(b[16:0]);
        s4_next.last = s3_reg.last;
        s4_next.x    = s3_reg.x;
        s4_next.y    = s3_reg.y;
        s4_next.z    = s3_reg.z;
        s4_next.grey = g[23:16];
        s4_next.u    = s3_reg.u;
        s4_next.v    = s3_reg.v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= busy_reg;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (s4_en)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_reg <= s1_next;
        if (s2_en)
            s2_reg <= s2_next;
        if (s3_en)
            s3_reg <= s3_next;
        if (s4_en)
            s4_reg <= s4_next;
    end

    assign vertex.valid       = s4_valid_reg;
    assign vertex.vert_x      = s4_reg.x;
    assign vertex.vert_y      = s4_reg.y;
    assign vertex.vert_z      = s4_reg.z;
    assign vertex.grey_level  = s4_reg.grey;
    assign vertex.tex_u       = s4_reg.u;
    assign vertex.tex_v       = s4_reg.v;
    assign vertex.last_vertex = s4_reg.last;

    // a new face only lands while idle or on the last vertex of the current one
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!busy_reg || step_reg == VERT_LAST))
        else $error("face taken mid-face");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= VERT_LAST))
        else $error("vertex counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !s1_en) |=> $stable(step_reg) && busy_reg)
        else $error("sequencer moved while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        take_live |=> busy_reg && step_reg == 3'd0)
        else $error("visible face did not start at vertex zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_en) |=> s1_valid_reg && $stable(s1_reg))
        else $error("stage 1 lost data under stall");

endmodule

// ===== sim/tb_voxel_face_vertex_emitter.sv =====
// Testbench for the voxel face vertex emitter: directed and random faces against a vertex predictor.
module tb_voxel_face_vertex_emitter
    import vfve_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int TILE_SPAN    = 65536 / ATLAS_TILES_PER_ROW;

    // Triangle corner orders, vertex k in bits [2k+1:2k]
    localparam logic [11:0] TRI_A_EVEN = 12'b11_01_00_10_11_00;
    localparam logic [11:0] TRI_A_ODD  = 12'b11_10_00_01_11_00;
    localparam logic [11:0] TRI_B_EVEN = 12'b10_11_01_10_01_00;
    localparam logic [11:0] TRI_B_ODD  = 12'b01_11_10_01_10_00;

    typedef struct {
        logic [2:0]         face;
        logic               visible;
        logic [7:0]         tile;
        logic [35:0]        ao;
        logic [35:0]        lt;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [8:0]         half;
    } face_item_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  grey;
        logic [15:0] u;
        logic [15:0] v;
        logic        last;
    } vertex_t;

    logic clk;
    logic rst_n;

    vfve_face_if face_bus ();
    vfve_vert_if vert_bus ();

    voxel_face_vertex_emitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .face_item (face_bus),
        .vertex    (vert_bus)
    );

    vertex_t vertex_q[$];
    int      errors;
    int      cycle_count = 0;
    int      faces_sent;
    int      faces_emitting;
    int      faces_flipped;
    int      vertices_checked;
    int      positions_clamped;
    bit      idle_on;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("voxel_face_vertex_emitter: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] uv_flags(logic [2:0] face);
        // {corner3, corner2, corner1, corner0}, each {u far, v far}
        case (face)
            FACE_NEG_X: return 8'b11_01_10_00;
            FACE_POS_X: return 8'b01_11_00_10;
            FACE_POS_Y: return 8'b10_11_00_01;
            FACE_NEG_Y: return 8'b11_10_01_00;
            FACE_NEG_Z: return 8'b11_10_01_00;
            default:    return 8'b01_00_11_10;
        endcase
    endfunction

    function automatic longint face_factor(logic [2:0] face);
        case (face)
            FACE_NEG_X, FACE_POS_X: return 39322;
            FACE_POS_Y:             return 65536;
            FACE_NEG_Y:             return 32768;
            default:                return 52429;
        endcase
    endfunction

    function automatic logic [7:0] grey_byte(logic [2:0] face, longint ao, longint lt);
        longint aof;
        longint br;
        longint level;
        aof = 19661 + ((45875 * (131072 - ao * 256)) >>> 16) - 45875;
        br = (aof > 0) ? (face_factor(face) * aof) >>> 16 : 0;
        level = lt * 256;
        if (br > level)
            level = br;
        if (level > 65536)
            level = 65536;
        return 8'((level * 255) >>> 16);
    endfunction

    function automatic logic [15:0] atlas_coord(int index, logic far_edge);
        longint c;
        c = longint'(index) * TILE_SPAN + (far_edge ? TILE_SPAN - UV_INSET : UV_INSET);
        return (c > 65535) ? 16'hFFFF : 16'(c);
    endfunction

    // Works out the six vertices of a face, or none for a hidden one or a face code past five
    function automatic void predict_face(face_item_t it);
        longint     ao[4];
        longint     lt[4];
        longint     centre[3];
        longint     p;
        logic [11:0] order;
        logic [1:0] j;
        logic [1:0] uvf;
        logic [7:0] uv_all;
        logic       flip;
        logic       plus;
        int         fixed_axis;
        int         lower_axis;
        vertex_t    vx;
        logic [31:0] pos[3];
        if (!it.visible || it.face > 3'd5)
            return;
        for (int k = 0; k < 4; k++)
        begin
            ao[k] = it.ao[9 * k +: 9];
            lt[k] = it.lt[9 * k +: 9];
        end
        centre[0] = it.cx;
        centre[1] = it.cy;
        centre[2] = it.cz;
        flip = (ao[0] + ao[3]) > (ao[1] + ao[2]);
        if (it.face[0])
            order = flip ? TRI_B_ODD : TRI_A_ODD;
        else
            order = flip ? TRI_B_EVEN : TRI_A_EVEN;
        fixed_axis = it.face / 2;
        lower_axis = (fixed_axis == 0) ? 1 : 0;
        uv_all     = uv_flags(it.face);
        faces_emitting++;
        if (flip)
            faces_flipped++;
        for (int k = 0; k < 6; k++)
        begin
            j = order[2 * k +: 2];
            // face axis takes the face sign, the other two follow the corner bits
            for (int a = 0; a < 3; a++)
            begin
                if (a == fixed_axis)
                    plus = (it.face == FACE_POS_X) || (it.face == FACE_POS_Y)
                           || (it.face == FACE_POS_Z);
                else if (a == lower_axis)
                    plus = j[1];
                else
                    plus = j[0];
                p = plus ? centre[a] + longint'(it.half) : centre[a] - longint'(it.half);
                if (p > 64'sd2147483647)
                begin
                    p = 64'sd2147483647;
                    positions_clamped++;
                end
                if (p < -64'sd2147483648)
                begin
                    p = -64'sd2147483648;
                    positions_clamped++;
                end
                pos[a] = p[31:0];
            end
            uvf     = uv_all[2 * j +: 2];
            vx.x    = pos[0];
            vx.y    = pos[1];
            vx.z    = pos[2];
            vx.grey = grey_byte(it.face, ao[j], lt[j]);
            vx.u    = atlas_coord(it.tile % ATLAS_TILES_PER_ROW, uvf[1]);
            vx.v    = atlas_coord(it.tile / ATLAS_TILES_PER_ROW, uvf[0]);
            vx.last = (k == 5);
            vertex_q.push_back(vx);
        end
    endfunction

    task automatic send_face(input face_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            face_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        face_bus.valid         <= 1'b1;
        face_bus.face          <= it.face;
        face_bus.face_visible  <= it.visible;
        face_bus.tile          <= it.tile;
        face_bus.ao_corners    <= it.ao;
        face_bus.light_corners <= it.lt;
        face_bus.centre_x      <= it.cx;
        face_bus.centre_y      <= it.cy;
        face_bus.centre_z      <= it.cz;
        face_bus.half_size     <= it.half;
        @(posedge clk);
        while (!face_bus.ready)
            @(posedge clk);
        predict_face(it);
        faces_sent++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: vertex %0d %s expected %h actual %h",
                     $time, vertices_checked, name, want, got);
        end
    endtask

    task automatic check_vertex();
        vertex_t want;
        if (vertex_q.size() == 0)
        begin
            errors++;
            $display("%0t ns: vertex with nothing expected, expected none actual %h %h %h",
                     $time, vert_bus.vert_x, vert_bus.vert_y, vert_bus.vert_z);
            return;
        end
        want = vertex_q.pop_front();
        compare_field("vert_x", want.x, vert_bus.vert_x);
        compare_field("vert_y", want.y, vert_bus.vert_y);
        compare_field("vert_z", want.z, vert_bus.vert_z);
        compare_field("grey_level", 32'(want.grey), 32'(vert_bus.grey_level));
        compare_field("tex_u", 32'(want.u), 32'(vert_bus.tex_u));
        compare_field("tex_v", 32'(want.v), 32'(vert_bus.tex_v));
        compare_field("last_vertex", 32'(want.last), 32'(vert_bus.last_vertex));
        vertices_checked++;
    endtask

    // Vertex sink: random stalls, check every transfer
    initial
    begin : vertex_sink
        int stall;
        vert_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                vert_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            vert_bus.ready <= 1'b1;
            @(posedge clk);
            while (!vert_bus.valid)
                @(posedge clk);
            check_vertex();
        end
    end

    function automatic logic [35:0] pack4(logic [8:0] c0, logic [8:0] c1,
                                          logic [8:0] c2, logic [8:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic face_item_t make_face(logic [2:0] face, logic visible, logic [7:0] tile,
                                             logic [35:0] ao, logic [35:0] lt,
                                             logic [31:0] cx, logic [31:0] cy,
                                             logic [31:0] cz, logic [8:0] half);
        face_item_t it;
        it.face    = face;
        it.visible = visible;
        it.tile    = tile;
        it.ao      = ao;
        it.lt      = lt;
        it.cx      = cx;
        it.cy      = cy;
        it.cz      = cz;
        it.half    = half;
        return it;
    endfunction

    function automatic logic [35:0] random_corners();
        logic [35:0] r;
        case ($urandom_range(0, 3))
            0:
            begin
                for (int k = 0; k < 4; k++)
                    case ($urandom_range(0, 2))
                        0:       r[9 * k +: 9] = 9'd0;
                        1:       r[9 * k +: 9] = 9'h1FF;
                        default: r[9 * k +: 9] = 9'($urandom);
                    endcase
            end
            1:
            begin
                for (int k = 0; k < 4; k++)
                    r[9 * k +: 9] = 9'($urandom_range(0, 64));
            end
            default: r = {4'($urandom), 32'($urandom)};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 600));
            1:       return 32'h8000_0000 + 32'($urandom_range(0, 600));
            default: return $urandom;
        endcase
    endfunction

    function automatic face_item_t random_face();
        face_item_t it;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            it.face    = 3'($urandom_range(6, 7));
            it.visible = 1'b1;
        end
        else if (r <= 2)
        begin
            it.face    = 3'($urandom_range(0, 7));
            it.visible = 1'b0;
        end
        else
        begin
            it.face    = 3'($urandom_range(0, 5));
            it.visible = 1'b1;
        end
        it.tile = 8'($urandom_range(0, 255));
        it.ao   = random_corners();
        it.lt   = random_corners();
        it.cx   = random_coord();
        it.cy   = random_coord();
        it.cz   = random_coord();
        case ($urandom_range(0, 9))
            0:       it.half = 9'd0;
            1:       it.half = 9'd256;
            2:       it.half = 9'h1FF;
            default: it.half = 9'($urandom_range(0, 511));
        endcase
        return it;
    endfunction

    task automatic wait_drained();
        face_bus.valid <= 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_each_face();
        logic [35:0] ao;
        logic [35:0] lt;
        ao = pack4(9'd40, 9'd300, 9'd128, 9'd0);
        lt = pack4(9'd10, 9'd200, 9'd64, 9'h1FF);
        send_face(make_face(FACE_NEG_X, 1'b1, 8'd37, ao, lt, 32'd1000, -32'd2000, 32'd3000,
                            9'd128));
        send_face(make_face(FACE_POS_X, 1'b1, 8'd37, ao, lt, 32'd1000, -32'd2000, 32'd3000,
                            9'd128));
        send_face(make_face(FACE_POS_Y, 1'b1, 8'd90, ao, lt, -32'd5, 32'd77, 32'd0, 9'd64));
        send_face(make_face(FACE_NEG_Y, 1'b1, 8'd90, ao, lt, -32'd5, 32'd77, 32'd0, 9'd64));
        send_face(make_face(FACE_NEG_Z, 1'b1, 8'd200, ao, lt, 32'd256, 32'd256, 32'd256,
                            9'd256));
        send_face(make_face(FACE_POS_Z, 1'b1, 8'd200, ao, lt, 32'd256, 32'd256, 32'd256,
                            9'd256));
    endtask

    task automatic test_hidden_faces();
        logic [35:0] ao;
        ao = pack4(9'd1, 9'd2, 9'd3, 9'd4);
        send_face(make_face(FACE_POS_Y, 1'b0, 8'd5, ao, ao, 32'd1, 32'd2, 32'd3, 9'd10));
        // face codes past the last face behave as hidden
        send_face(make_face(3'd6, 1'b1, 8'd5, ao, ao, 32'd1, 32'd2, 32'd3, 9'd10));
        send_face(make_face(3'd7, 1'b1, 8'd5, ao, ao, 32'd1, 32'd2, 32'd3, 9'd10));
    endtask

    task automatic test_occlusion_extremes();
        send_face(make_face(FACE_POS_Y, 1'b1, 8'd1, '0, '0, 32'd0, 32'd0, 32'd0, 9'd100));
        // heavy occlusion drives the factor negative: light alone remains
        send_face(make_face(FACE_POS_Y, 1'b1, 8'd1, '1, '0, 32'd0, 32'd0, 32'd0, 9'd100));
        send_face(make_face(FACE_NEG_Z, 1'b1, 8'd1, '1, '1, 32'd0, 32'd0, 32'd0, 9'd100));
    endtask

    task automatic test_light_extremes();
        send_face(make_face(FACE_NEG_Y, 1'b1, 8'd2, '0, '1, 32'd9, 32'd9, 32'd9, 9'd1));
        send_face(make_face(FACE_POS_X, 1'b1, 8'd2, pack4(9'd0, 9'h1FF, 9'd256, 9'd128),
                            pack4(9'h1FF, 9'd0, 9'd256, 9'd255), 32'd9, 32'd9, 32'd9,
                            9'd1));
    endtask

    task automatic test_position_saturation();
        logic [35:0] ao;
        ao = pack4(9'd20, 9'd40, 9'd60, 9'd80);
        send_face(make_face(FACE_POS_X, 1'b1, 8'd3, ao, ao, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 9'h1FF));
        send_face(make_face(FACE_NEG_X, 1'b1, 8'd3, ao, ao, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 9'h1FF));
        send_face(make_face(FACE_NEG_Z, 1'b1, 8'd3, ao, ao, 32'h7FFF_FF80, 32'h8000_0040,
                            32'hFFFF_FFFF, 9'd300));
    endtask

    task automatic test_tile_extremes();
        logic [35:0] ao;
        ao = pack4(9'd100, 9'd0, 9'd0, 9'd0);
        send_face(make_face(FACE_POS_Z, 1'b1, 8'd0, ao, ao, 32'd0, 32'd0, 32'd0, 9'd50));
        send_face(make_face(FACE_NEG_X, 1'b1, 8'd255, ao, ao, 32'd0, 32'd0, 32'd0, 9'd50));
        send_face(make_face(FACE_POS_Y, 1'b1, 8'd15, ao, ao, 32'd0, 32'd0, 32'd0, 9'd50));
        send_face(make_face(FACE_NEG_Y, 1'b1, 8'd240, ao, ao, 32'd0, 32'd0, 32'd0, 9'd50));
    endtask

    task automatic test_triangle_flip();
        logic [35:0] flipped;
        logic [35:0] even_sums;
        flipped   = pack4(9'd200, 9'd10, 9'd20, 9'd150);
        even_sums = pack4(9'd100, 9'd60, 9'd90, 9'd50);
        send_face(make_face(FACE_POS_Y, 1'b1, 8'd77, flipped, '0, 32'd12, 32'd34, 32'd56,
                            9'd200));
        send_face(make_face(FACE_POS_X, 1'b1, 8'd77, flipped, '0, 32'd12, 32'd34, 32'd56,
                            9'd200));
        // equal diagonal sums keep the normal order
        send_face(make_face(FACE_POS_Z, 1'b1, 8'd77, even_sums, '0, 32'd12, 32'd34, 32'd56,
                            9'd200));
    endtask

    task automatic test_random_faces(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 46 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            // hold off once until the pipe is empty
            if (n == count / 2)
                wait_drained();
            send_face(random_face());
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        errors            = 0;
        faces_sent        = 0;
        faces_emitting    = 0;
        faces_flipped     = 0;
        vertices_checked  = 0;
        positions_clamped = 0;
        idle_on           = 1'b1;
        rst_n                  <= 1'b0;
        face_bus.valid         <= 1'b0;
        face_bus.face          <= '0;
        face_bus.face_visible  <= 1'b0;
        face_bus.tile          <= '0;
        face_bus.ao_corners    <= '0;
        face_bus.light_corners <= '0;
        face_bus.centre_x      <= '0;
        face_bus.centre_y      <= '0;
        face_bus.centre_z      <= '0;
        face_bus.half_size     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_face();
        test_hidden_faces();
        test_occlusion_extremes();
        test_light_extremes();
        test_position_saturation();
        test_tile_extremes();
        test_triangle_flip();
        test_random_faces(436);

        face_bus.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d faces sent, %0d emitting (%0d with flipped diagonal), %0d vertices checked",
                 faces_sent, faces_emitting, faces_flipped, vertices_checked);
        $display("%0d clamped coordinates, all six faces, hidden codes and atlas corners",
                 positions_clamped);
        if (errors == 0 && vertex_q.size() == 0)
            $display("voxel_face_vertex_emitter: match");
        else
            $display("voxel_face_vertex_emitter: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/vfve_pkg.sv
design/vfve_face_if.sv
design/vfve_vert_if.sv
design/voxel_face_vertex_emitter.sv
sim/tb_voxel_face_vertex_emitter.sv
